// ===== hw/rtl/jcm_pkg.sv =====
package jcm_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int JOY_W      = 12;
    localparam int POS_X_W    = 7;
    localparam int POS_Y_W    = 6;
    localparam int SPEED_W    = 5;
    localparam int BTN_W      = 2;
    localparam int EDGE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Motion arithmetic
    localparam int ACC_W      = 14;               // signed 1/256-pixel accumulator
    localparam int FRAC_BITS  = 8;                // 256 sub-steps per pixel
    localparam int MAG_W      = 11;               // saturated deflection magnitude
    localparam int REC_SHIFT  = 24;               // reciprocal scaling for divide-by-constant
    localparam int REC_W      = 14;

    localparam logic [JOY_W:0]   JOY_CENTER = (JOY_W + 1)'(2047);
    localparam logic [MAG_W-1:0] DEFL_MAX   = MAG_W'(2047);
    localparam logic [JOY_W-1:0] JOY_FULL   = JOY_W'(4095);

    localparam logic [REC_W-1:0] REC_DEFL = REC_W'((64'd1 << REC_SHIFT) / 64'd2047);
    localparam logic [REC_W-1:0] REC_FULL = REC_W'((64'd1 << REC_SHIFT) / 64'd4095);

    localparam logic [TIME_W-1:0] MOVE_PERIOD_MS = TIME_W'(16);

    // Speed register limits and reset
    localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(1);
    localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(20);
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(3);

    // Cursor reset position
    localparam logic [POS_X_W-1:0] POS_X_RESET = POS_X_W'(64);
    localparam logic [POS_Y_W-1:0] POS_Y_RESET = POS_Y_W'(32);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = CFG_IDX_W'(2);

    // Click button codes
    localparam logic [BTN_W-1:0] BTN_B = BTN_W'(0);
    localparam logic [BTN_W-1:0] BTN_A = BTN_W'(1);
    localparam logic [BTN_W-1:0] BTN_X = BTN_W'(2);
    localparam logic [BTN_W-1:0] BTN_Y = BTN_W'(3);

    // Hardware ids of consumed edges
    localparam logic [EDGE_W-1:0] EDGE_Y    = EDGE_W'(0);
    localparam logic [EDGE_W-1:0] EDGE_A    = EDGE_W'(1);
    localparam logic [EDGE_W-1:0] EDGE_X    = EDGE_W'(2);
    localparam logic [EDGE_W-1:0] EDGE_B    = EDGE_W'(3);
    localparam logic [EDGE_W-1:0] EDGE_NONE = EDGE_W'(4);

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [JOY_W-1:0]  joy_x;
        logic [JOY_W-1:0]  joy_y;
        logic              press_b;
        logic              press_a;
        logic              press_x;
        logic              press_y;
        logic              take_click;
    } in_word_t;

    typedef struct packed {
        logic [POS_X_W-1:0] cursor_x;
        logic [POS_Y_W-1:0] cursor_y;
        logic               click_valid;
        logic [BTN_W-1:0]   click_button;
        logic [EDGE_W-1:0]  edge_consumed;
    } out_word_t;

    // Part of an input word carried past the lanes to the merge stage
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              press_b;
        logic              press_a;
        logic              press_x;
        logic              press_y;
        logic              take_click;
    } side_t;

    // Load enables of the three lane pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

// ===== hw/rtl/jcm_in_if.sv =====
interface jcm_in_if;
    import jcm_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/jcm_out_if.sv =====
interface jcm_out_if;
    import jcm_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/jcm_axis_lane.sv =====
module jcm_axis_lane #(
    parameter int POS_W = jcm_pkg::POS_X_W
) (
    input  logic                               clk,
    input  jcm_pkg::pipe_en_t                  en,
    input  logic [jcm_pkg::JOY_W-1:0]          joy,
    input  logic [jcm_pkg::SPEED_W-1:0]        speed,
    output logic signed [jcm_pkg::ACC_W-1:0]   term,
    output logic [POS_W-1:0]                   abs_pos
);
    import jcm_pkg::*;

    localparam int M_W  = MAG_W + SPEED_W;          // deflection * speed
    localparam int N_W  = M_W + FRAC_BITS;          // scaled to 1/256 pixel
    localparam int P_W  = N_W + REC_W;
    localparam int Q_W  = ACC_W - 1;                // step magnitude
    localparam int NA_W = JOY_W + POS_W;            // sample * full-scale position
    localparam int PA_W = NA_W + REC_W;
    localparam logic [NA_W-1:0] POS_MAX = NA_W'((1 << POS_W) - 1);

    // Stage 0: deflection from center, saturate, multiply by speed; scale the sample by full-scale position
    logic signed [JOY_W:0] dev;
    logic                  neg_next;
    logic [JOY_W:0]        dev_mag;
    logic [MAG_W-1:0]      mag;
    logic [M_W-1:0]        m_next;
    logic [NA_W-1:0]       na_next;

    always_comb
    begin
        dev      = $signed({1'b0, joy}) - $signed(JOY_CENTER);
        neg_next = dev[JOY_W];
        dev_mag  = neg_next ? (JOY_W + 1)'(-dev) : (JOY_W + 1)'(dev);
        if (dev_mag > (JOY_W + 1)'(DEFL_MAX))
        begin
            mag = DEFL_MAX;
        end
        else
        begin
            mag = dev_mag[MAG_W-1:0];
        end
        m_next  = M_W'(mag) * M_W'(speed);
        na_next = NA_W'(joy) * POS_MAX;
    end

    logic [M_W-1:0]  m1_reg;
    logic            neg1_reg;
    logic [NA_W-1:0] na1_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            m1_reg   <= m_next;
            neg1_reg <= neg_next;
            na1_reg  <= na_next;
        end
    end

    // Stage 1: quotient estimates by reciprocal multiply
    logic [N_W-1:0]  n_next;
    logic [P_W-1:0]  p;
    logic [Q_W-1:0]  q0_next;
    logic [PA_W-1:0] pa;
    logic [POS_W-1:0] qa0_next;

    always_comb
    begin
        n_next   = {m1_reg, FRAC_BITS'(0)};
        p        = P_W'(n_next) * P_W'(REC_DEFL);
        q0_next  = p[REC_SHIFT +: Q_W];
        pa       = PA_W'(na1_reg) * PA_W'(REC_FULL);
        qa0_next = pa[REC_SHIFT +: POS_W];
    end

    logic [N_W-1:0]   n2_reg;
    logic [Q_W-1:0]   q02_reg;
    logic             neg2_reg;
    logic [NA_W-1:0]  na2_reg;
    logic [POS_W-1:0] qa02_reg;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            n2_reg   <= n_next;
            q02_reg  <= q0_next;
            neg2_reg <= neg1_reg;
            na2_reg  <= na1_reg;
            qa02_reg <= qa0_next;
        end
    end

    // Stage 2: correct each estimate by one, apply sign
    logic [N_W-1:0]          rem;
    logic [Q_W-1:0]          q;
    logic signed [ACC_W-1:0] term_next;
    logic [NA_W-1:0]         rem_a;
    logic [POS_W-1:0]        abs_next;

    always_comb
    begin
        rem = n2_reg - N_W'(q02_reg) * N_W'(DEFL_MAX);
        q   = q02_reg + Q_W'(rem >= N_W'(DEFL_MAX));
        if (neg2_reg)
        begin
            term_next = -$signed({1'b0, q});
        end
        else
        begin
            term_next = $signed({1'b0, q});
        end
        rem_a    = na2_reg - NA_W'(qa02_reg) * NA_W'(JOY_FULL);
        abs_next = qa02_reg + POS_W'(rem_a >= NA_W'(JOY_FULL));
    end

    logic signed [ACC_W-1:0] term_reg;
    logic [POS_W-1:0]        abs_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            term_reg <= term_next;
            abs_reg  <= abs_next;
        end
    end

    assign term    = term_reg;
    assign abs_pos = abs_reg;

endmodule

// ===== hw/rtl/jcm_merge.sv =====
module jcm_merge #(
    parameter logic [jcm_pkg::TIME_W-1:0] MOVE_PERIOD_MS = jcm_pkg::MOVE_PERIOD_MS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jcm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              commit,
    input  jcm_pkg::side_t                    side,
    input  logic signed [jcm_pkg::ACC_W-1:0]  term_x,
    input  logic signed [jcm_pkg::ACC_W-1:0]  term_y,
    input  logic [jcm_pkg::POS_X_W-1:0]       abs_x,
    input  logic [jcm_pkg::POS_Y_W-1:0]       abs_y,
    output logic [jcm_pkg::SPEED_W-1:0]       speed,
    output jcm_pkg::out_word_t                res
);
    import jcm_pkg::*;

    localparam int SP_W = POS_X_W + 2;    // signed position with headroom for a step

    typedef struct packed {
        logic [POS_X_W-1:0]      pos;
        logic signed [ACC_W-1:0] acc;
    } axis_t;

    // Add a term, move by whole pixels toward zero, clamp and clear on an edge
    function automatic axis_t axis_move(
        input logic [POS_X_W-1:0]      pos,
        input logic [POS_X_W-1:0]      pmax,
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] add
    );
        logic signed [ACC_W-1:0] sum;
        logic [ACC_W-2:0]        smag;
        logic signed [SP_W-1:0]  step;
        logic signed [ACC_W-1:0] rem;
        logic signed [SP_W-1:0]  npos;
        axis_t                   r;
        sum = acc + add;
        if (sum < 0)
        begin
            smag = (ACC_W - 1)'(-sum);
            step = -$signed(SP_W'(smag[ACC_W-2:FRAC_BITS]));
            rem  = -$signed(ACC_W'(smag[FRAC_BITS-1:0]));
        end
        else
        begin
            smag = sum[ACC_W-2:0];
            step = $signed(SP_W'(smag[ACC_W-2:FRAC_BITS]));
            rem  = $signed(ACC_W'(smag[FRAC_BITS-1:0]));
        end
        npos  = $signed(SP_W'(pos)) + step;
        r.pos = npos[POS_X_W-1:0];
        r.acc = rem;
        if (npos < 0)
        begin
            r.pos = '0;
            r.acc = '0;
        end
        else if (npos > $signed(SP_W'(pmax)))
        begin
            r.pos = pmax;
            r.acc = '0;
        end
        return r;
    endfunction

    logic                      enabled_reg;
    logic                      abs_mode_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [POS_X_W-1:0]        pos_x_reg, pos_x_next;
    logic [POS_Y_W-1:0]        pos_y_reg, pos_y_next;
    logic [TIME_W-1:0]         last_move_reg, last_move_next;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0]   acc_y_reg, acc_y_next;
    logic                      latched_reg, latched_next;
    logic [BTN_W-1:0]          button_reg, button_next;

    logic [TIME_W-1:0]         elapsed;
    axis_t                     mx;
    axis_t                     my;
    logic [EDGE_W-1:0]         consumed;
    logic                      click_valid;
    logic [BTN_W-1:0]          click_button;
    logic                      cfg_clear;
    logic [SPEED_W-1:0]        speed_sat;

    // Cursor update and click latch for the word leaving the lanes
    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        last_move_next = last_move_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        latched_next   = latched_reg;
        button_next    = button_reg;
        consumed       = EDGE_NONE;
        click_valid    = 1'b0;
        click_button   = BTN_B;
        elapsed        = side.now_ms - last_move_reg;
        mx = axis_move(pos_x_reg, POS_X_W'((1 << POS_X_W) - 1), acc_x_reg, term_x);
        my = axis_move(POS_X_W'(pos_y_reg), POS_X_W'((1 << POS_Y_W) - 1), acc_y_reg, term_y);

        if (enabled_reg)
        begin
            if (abs_mode_reg)
            begin
                pos_x_next = abs_x;
                pos_y_next = abs_y;
            end
            else if (elapsed >= MOVE_PERIOD_MS)
            begin
                last_move_next = side.now_ms;
                pos_x_next     = mx.pos;
                acc_x_next     = mx.acc;
                pos_y_next     = my.pos[POS_Y_W-1:0];
                acc_y_next     = my.acc;
            end

            if (side.press_b)
            begin
                button_next = BTN_B;
                consumed    = EDGE_B;
            end
            else if (side.press_a)
            begin
                button_next = BTN_A;
                consumed    = EDGE_A;
            end
            else if (side.press_x)
            begin
                button_next = BTN_X;
                consumed    = EDGE_X;
            end
            else if (side.press_y)
            begin
                button_next = BTN_Y;
                consumed    = EDGE_Y;
            end
            if (consumed != EDGE_NONE)
            begin
                latched_next = 1'b1;
            end
        end

        // Serve a take request after the update
        if (side.take_click && latched_next)
        begin
            latched_next = 1'b0;
            click_valid  = 1'b1;
            click_button = button_next;
        end
    end

    always_comb
    begin
        res.cursor_x      = pos_x_next;
        res.cursor_y      = pos_y_next;
        res.click_valid   = click_valid;
        res.click_button  = click_button;
        res.edge_consumed = consumed;
    end

    // Configuration decode: saturate speed, detect motion clear
    always_comb
    begin
        if (cfg_wdata < SPEED_MIN)
        begin
            speed_sat = SPEED_MIN;
        end
        else if (cfg_wdata > SPEED_MAX)
        begin
            speed_sat = SPEED_MAX;
        end
        else
        begin
            speed_sat = cfg_wdata;
        end
        cfg_clear = cfg_we &&
                    ((cfg_index == CFG_ENABLED && cfg_wdata[0] && !enabled_reg) ||
                     cfg_index == CFG_ABS_MODE);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            abs_mode_reg <= 1'b0;
            speed_reg    <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLED:  enabled_reg  <= cfg_wdata[0];
                CFG_ABS_MODE: abs_mode_reg <= cfg_wdata[0];
                CFG_SPEED:    speed_reg    <= speed_sat;
                default:      ;
            endcase
        end
    end

    // Cursor state: advance on commit, clear motion on a mode write or a write that enables a disabled block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= POS_X_RESET;
            pos_y_reg     <= POS_Y_RESET;
            last_move_reg <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            latched_reg   <= 1'b0;
            button_reg    <= BTN_B;
        end
        else if (cfg_clear)
        begin
            last_move_reg <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
        end
        else if (commit)
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            last_move_reg <= last_move_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            latched_reg   <= latched_next;
            button_reg    <= button_next;
        end
    end

    assign speed = speed_reg;

endmodule

// ===== hw/rtl/joystick_cursor_motion.sv =====
// Path: a word accepted on the input passes the three registered lane stages and the merge
// stage, which loads the output register. Throughput: one word per cycle while the output
// is taken, else the stages hold; the X and Y lanes scale both axes in parallel and the
// merge stage updates cursor and click state once per word.
// Reset (rst_n, asynchronous, active low): pipeline empty, cursor at (64, 32),
// accumulators, move time and click latch cleared, block disabled, speed 3.
module joystick_cursor_motion #(
    parameter logic [jcm_pkg::TIME_W-1:0] MOVE_PERIOD_MS = jcm_pkg::MOVE_PERIOD_MS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    jcm_in_if.sink                         in_ch,
    jcm_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [jcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import jcm_pkg::*;

    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic out_free;
    logic commit;
    pipe_en_t en;

    side_t     side0;
    side_t     side1_reg, side2_reg, side3_reg;
    out_word_t res;
    out_word_t out_reg;

    logic [SPEED_W-1:0]        speed;
    logic signed [ACC_W-1:0]   term_x, term_y;
    logic [POS_X_W-1:0]        abs_x;
    logic [POS_Y_W-1:0]        abs_y;

    // Stage enables: a stage loads when empty or when its word moves on
    always_comb
    begin
        out_free = !ov_reg || out_ch.ready;
        en.s3    = !v3_reg || out_free;
        en.s2    = !v2_reg || en.s3;
        en.s1    = !v1_reg || en.s2;
        commit   = v3_reg && out_free;
    end

    assign in_ch.ready = en.s1;

    // Valid bits of the pipeline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_ch.valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (out_free)
            begin
                ov_reg <= v3_reg;
            end
        end
    end

    always_comb
    begin
        side0.now_ms     = in_ch.data.now_ms;
        side0.press_b    = in_ch.data.press_b;
        side0.press_a    = in_ch.data.press_a;
        side0.press_x    = in_ch.data.press_x;
        side0.press_y    = in_ch.data.press_y;
        side0.take_click = in_ch.data.take_click;
    end

    // Carry time and button fields alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            side1_reg <= side0;
        end
        if (en.s2)
        begin
            side2_reg <= side1_reg;
        end
        if (en.s3)
        begin
            side3_reg <= side2_reg;
        end
        if (out_free)
        begin
            out_reg <= res;
        end
    end

    jcm_axis_lane #(
        .POS_W (POS_X_W)
    ) u_lane_x (
        .clk     (clk),
        .en      (en),
        .joy     (in_ch.data.joy_x),
        .speed   (speed),
        .term    (term_x),
        .abs_pos (abs_x)
    );

    jcm_axis_lane #(
        .POS_W (POS_Y_W)
    ) u_lane_y (
        .clk     (clk),
        .en      (en),
        .joy     (in_ch.data.joy_y),
        .speed   (speed),
        .term    (term_y),
        .abs_pos (abs_y)
    );

    jcm_merge #(
        .MOVE_PERIOD_MS (MOVE_PERIOD_MS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .commit    (commit),
        .side      (side3_reg),
        .term_x    (term_x),
        .term_y    (term_y),
        .abs_x     (abs_x),
        .abs_y     (abs_y),
        .speed     (speed),
        .res       (res)
    );

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = out_reg;

endmodule

// ===== tb/jcm_motion_checker.sv =====
module jcm_motion_checker
    import jcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    jcm_in_if                     in_mon,
    jcm_out_if                    out_mon,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int CENTER     = int'(JOY_CENTER);
    localparam int DEFL_LIM   = int'(DEFL_MAX);
    localparam int FULL_SCALE = int'(JOY_FULL);
    localparam int ONE_PIXEL  = 1 << FRAC_BITS;
    localparam int X_EDGE     = (1 << POS_X_W) - 1;
    localparam int Y_EDGE     = (1 << POS_Y_W) - 1;

    // Register copies
    logic              cur_enabled;
    logic              cur_abs;
    int                cur_speed;

    // Cursor and click state
    int                pos_x;
    int                pos_y;
    int                acc_x;
    int                acc_y;
    logic [TIME_W-1:0] last_move_ms;
    logic              click_held;
    logic [BTN_W-1:0]  held_button;

    // Result words predicted but not yet seen on the output
    out_word_t         cursor_q[$];

    function automatic int deflect(input logic [JOY_W-1:0] raw);
        int d;
        d = int'(raw) - CENTER;
        if (d > DEFL_LIM) d = DEFL_LIM;
        if (d < -DEFL_LIM) d = -DEFL_LIM;
        return d;
    endfunction

    task automatic park_motion();
        last_move_ms = '0;
        acc_x        = 0;
        acc_y        = 0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        int s;
        s = int'(val);
        case (idx)
            CFG_ENABLED:
            begin
                if (val[0] && !cur_enabled) park_motion();
                cur_enabled = val[0];
            end
            CFG_ABS_MODE:
            begin
                cur_abs = val[0];
                park_motion();
            end
            CFG_SPEED:
            begin
                if (s < int'(SPEED_MIN)) s = int'(SPEED_MIN);
                if (s > int'(SPEED_MAX)) s = int'(SPEED_MAX);
                cur_speed = s;
            end
            default:
            begin
            end
        endcase
    endtask

    // Advance the cursor by one tick and build the word it should produce
    task automatic move_cursor(input in_word_t w, output out_word_t r);
        logic [TIME_W-1:0] elapsed;
        int                step_x;
        int                step_y;
        r               = '0;
        r.edge_consumed = EDGE_NONE;
        if (cur_enabled)
        begin
            if (cur_abs)
            begin
                pos_x = int'(w.joy_x) * X_EDGE / FULL_SCALE;
                pos_y = int'(w.joy_y) * Y_EDGE / FULL_SCALE;
            end
            else
            begin
                elapsed = w.now_ms - last_move_ms;
                if (elapsed >= MOVE_PERIOD_MS)
                begin
                    last_move_ms = w.now_ms;
                    acc_x  += deflect(w.joy_x) * cur_speed * ONE_PIXEL / DEFL_LIM;
                    acc_y  += deflect(w.joy_y) * cur_speed * ONE_PIXEL / DEFL_LIM;
                    step_x  = acc_x / ONE_PIXEL;
                    step_y  = acc_y / ONE_PIXEL;
                    acc_x  -= step_x * ONE_PIXEL;
                    acc_y  -= step_y * ONE_PIXEL;
                    pos_x  += step_x;
                    pos_y  += step_y;
                    // Pin at the screen border and drop the fraction of that axis
                    if (pos_x < 0)      begin pos_x = 0;      acc_x = 0; end
                    if (pos_x > X_EDGE) begin pos_x = X_EDGE; acc_x = 0; end
                    if (pos_y < 0)      begin pos_y = 0;      acc_y = 0; end
                    if (pos_y > Y_EDGE) begin pos_y = Y_EDGE; acc_y = 0; end
                end
            end

            // Latch only the highest-priority press edge
            if (w.press_b)
            begin
                held_button     = BTN_B;
                r.edge_consumed = EDGE_B;
            end
            else if (w.press_a)
            begin
                held_button     = BTN_A;
                r.edge_consumed = EDGE_A;
            end
            else if (w.press_x)
            begin
                held_button     = BTN_X;
                r.edge_consumed = EDGE_X;
            end
            else if (w.press_y)
            begin
                held_button     = BTN_Y;
                r.edge_consumed = EDGE_Y;
            end
            if (r.edge_consumed != EDGE_NONE) click_held = 1'b1;
        end

        // Serve a take request after the update, even while disabled
        if (w.take_click && click_held)
        begin
            click_held     = 1'b0;
            r.click_valid  = 1'b1;
            r.click_button = held_button;
        end
        r.cursor_x = POS_X_W'(pos_x);
        r.cursor_y = POS_Y_W'(pos_y);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Track registers and input words, compare each output word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        in_word_t  tick;
        out_word_t want;
        out_word_t got;
        if (!rst_n)
        begin
            cur_enabled  = 1'b0;
            cur_abs      = 1'b0;
            cur_speed    = int'(SPEED_RESET);
            pos_x        = int'(POS_X_RESET);
            pos_y        = int'(POS_Y_RESET);
            park_motion();
            click_held   = 1'b0;
            held_button  = BTN_B;
            cursor_q.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_we) apply_register(cfg_index, cfg_wdata);

            if (in_mon.valid && in_mon.ready)
            begin
                tick = in_mon.data;
                move_cursor(tick, want);
                cursor_q.push_back(want);
            end

            if (out_mon.valid && out_mon.ready)
            begin
                got = out_mon.data;
                if (cursor_q.size() == 0)
                begin
                    $error("output word with no tick pending: x=%0d y=%0d",
                           got.cursor_x, got.cursor_y);
                    mismatches++;
                end
                else
                begin
                    want = cursor_q.pop_front();
                    check_field("cursor_x", want.cursor_x, got.cursor_x);
                    check_field("cursor_y", want.cursor_y, got.cursor_y);
                    check_field("click_valid", want.click_valid, got.click_valid);
                    check_field("click_button", want.click_button, got.click_button);
                    check_field("edge_consumed", want.edge_consumed, got.edge_consumed);
                end
            end
            outstanding = cursor_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import jcm_pkg::*;

    localparam int N_PHASES     = 8;
    localparam int PHASE_TICKS  = 125;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = CFG_IDX_W'(3);

    // Press masks, ordered {b, a, x, y}
    localparam logic [3:0] PR_NONE = 4'b0000;
    localparam logic [3:0] PR_B    = 4'b1000;
    localparam logic [3:0] PR_A    = 4'b0100;
    localparam logic [3:0] PR_X    = 4'b0010;
    localparam logic [3:0] PR_Y    = 4'b0001;
    localparam logic [3:0] PR_ALL  = 4'b1111;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    mismatches;
    int                    outstanding;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    bit                    hold_armed;

    // Register settings of the random phases
    bit                    enable_plan [N_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
    bit                    abs_plan    [N_PHASES] = '{0, 0, 1, 0, 0, 0, 1, 0};
    logic [CFG_DATA_W-1:0] speed_plan  [N_PHASES] = '{20, 0, 13, 5, 31, 3, 9, 7};

    jcm_in_if  in_ch();
    jcm_out_if out_ch();

    joystick_cursor_motion u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    jcm_motion_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive ready: random stalls, plus one long hold once armed
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run when no word moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        do
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        while (quiet < STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one tick word and hold it until accepted
    task automatic send_tick(input logic [TIME_W-1:0] now, input logic [JOY_W-1:0] jx,
                             input logic [JOY_W-1:0] jy, input logic [3:0] press,
                             input logic take);
        in_word_t w;
        w.now_ms     = now;
        w.joy_x      = jx;
        w.joy_y      = jy;
        w.press_b    = press[3];
        w.press_a    = press[2];
        w.press_x    = press[1];
        w.press_y    = press[0];
        w.take_click = take;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.data  <= w;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Drain the pipeline, then write one register
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [JOY_W-1:0] pick_joy(input logic [JOY_W-1:0] lean);
        case ($urandom_range(7))
            0:       return '0;
            1:       return JOY_FULL;
            2:       return JOY_W'(2043 + $urandom_range(8));
            3, 4, 5: return lean;
            default: return JOY_W'($urandom_range(4095));
        endcase
    endfunction

    initial
    begin
        logic [TIME_W-1:0] clock_ms;
        logic [JOY_W-1:0]  lean_x;
        logic [JOY_W-1:0]  lean_y;
        logic [3:0]        press;
        logic [CFG_DATA_W-1:0] spd;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        hold_armed    = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 51;
        lean_x        = '0;
        lean_y        = '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Disabled after reset: nothing latches, nothing moves
        send_tick(32'd100, JOY_FULL, '0, PR_ALL, 1'b1);

        cfg_write(CFG_ENABLED, 5'd1);
        // Inside and at the move period, wrap of the millisecond time
        send_tick(32'd5, JOY_FULL, '0, PR_Y, 1'b0);
        send_tick(32'd16, JOY_FULL, '0, PR_NONE, 1'b1);
        send_tick(32'hFFFF_FFFF, '0, JOY_FULL, PR_ALL, 1'b0);
        send_tick(32'd5, '0, JOY_FULL, PR_A | PR_X, 1'b1);
        send_tick(32'd21, 12'd3000, 12'd1000, PR_X, 1'b1);
        send_tick(32'd40, 12'd1500, 12'd2500, PR_NONE, 1'b1);
        send_tick(32'd100, 12'd2047, 12'd2047, PR_B, 1'b0);
        send_tick(32'd200, 12'd2048, 12'd2046, PR_NONE, 1'b0);

        // Disabled tick still hands out the latched click
        cfg_write(CFG_ENABLED, 5'd0);
        send_tick(32'd300, JOY_FULL, JOY_FULL, PR_A, 1'b1);

        // Full deflection at top speed until both axes pin
        cfg_write(CFG_ENABLED, 5'd1);
        cfg_write(CFG_SPEED, 5'd31);
        send_tick(32'd1000, JOY_FULL, JOY_FULL, PR_NONE, 1'b0);
        send_tick(32'd1016, JOY_FULL, JOY_FULL, PR_NONE, 1'b0);
        send_tick(32'd1032, JOY_FULL, JOY_FULL, PR_NONE, 1'b0);
        send_tick(32'd1048, JOY_FULL, JOY_FULL, PR_NONE, 1'b0);
        send_tick(32'd1064, '0, '0, PR_NONE, 1'b0);

        // Absolute mapping at the corners and the center
        cfg_write(CFG_ABS_MODE, 5'd1);
        send_tick(32'd1070, '0, '0, PR_NONE, 1'b0);
        send_tick(32'd1071, JOY_FULL, JOY_FULL, PR_NONE, 1'b0);
        send_tick(32'd1072, 12'd2047, 12'd2047, PR_NONE, 1'b0);
        send_tick(32'd1073, 12'd1, 12'd4094, PR_NONE, 1'b1);

        // Speed floor, back to relative, write to an unused index
        cfg_write(CFG_SPEED, 5'd0);
        cfg_write(CFG_ABS_MODE, 5'd0);
        cfg_write(CFG_NONE, 5'd31);
        send_tick(32'h8000_0000, '0, '0, PR_X, 1'b1);
        send_tick(32'h8000_0010, 12'd1000, 12'd3000, PR_NONE, 1'b0);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 51;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            spd = (ph == 5) ? CFG_DATA_W'($urandom_range(1, 20)) : speed_plan[ph];
            cfg_write(CFG_SPEED, spd);
            cfg_write(CFG_ABS_MODE, CFG_DATA_W'(abs_plan[ph]));
            cfg_write(CFG_ENABLED, CFG_DATA_W'(enable_plan[ph]));
            if (ph == 4) cfg_write(CFG_NONE, CFG_DATA_W'($urandom_range(31)));

            clock_ms = $urandom_range(1) ? 32'hFFFF_FFC0 : $urandom();
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // Hold a joystick lean for a while so the cursor reaches the borders
                if (n % 16 == 0)
                begin
                    lean_x = $urandom_range(1) ? JOY_W'($urandom_range(4095))
                                               : ($urandom_range(1) ? JOY_FULL : '0);
                    lean_y = $urandom_range(1) ? JOY_W'($urandom_range(4095))
                                               : ($urandom_range(1) ? JOY_FULL : '0);
                end

                // Mostly steady time steps around the move period, with jumps
                case ($urandom_range(19))
                    0:       clock_ms = $urandom();
                    1:       clock_ms = clock_ms - TIME_W'($urandom_range(1, 20));
                    2, 3:    clock_ms = clock_ms + TIME_W'($urandom_range(15));
                    default: clock_ms = clock_ms + TIME_W'($urandom_range(16, 24));
                endcase

                for (int b = 0; b < 4; b++)
                    press[b] = ($urandom_range(5) == 0);

                send_tick(clock_ms, pick_joy(lean_x), pick_joy(lean_y), press,
                          ($urandom_range(3) == 0));

                // Stall the receiver for a long stretch while ticks keep coming
                if (ph == 1 && n == 10) hold_armed = 1'b1;
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== joystick_cursor_motion.f =====
hw/rtl/jcm_pkg.sv
hw/rtl/jcm_in_if.sv
hw/rtl/jcm_out_if.sv
hw/rtl/jcm_axis_lane.sv
hw/rtl/jcm_merge.sv
hw/rtl/joystick_cursor_motion.sv
tb/jcm_motion_checker.sv
tb/tb_top.sv
